// ===== rtl/core/sobel_pkg.sv =====
package sobel_pkg;

  // Stream payload widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GRAD_W     = 11;
  localparam int unsigned SQ_W       = 20;
  localparam int unsigned MAG_W      = 21;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 48;

  // Line buffer geometry
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MIN_WIDTH  = 3;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);

  // Configuration port
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned THR_W      = 21;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 21;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [THR_W-1:0]   STRONG_RESET = THR_W'(90000);
  localparam logic [THR_W-1:0]   WEAK_RESET   = THR_W'(62500);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_STRONG_THR   = 2'd1,
    REG_WEAK_THR     = 2'd2
  } cfg_reg_e;

  typedef enum logic [CLASS_W-1:0] {
    EDGE_NONE   = 2'd0,
    EDGE_WEAK   = 2'd1,
    EDGE_STRONG = 2'd2
  } edge_class_e;

endpackage

// ===== rtl/core/sobel_edge_classifier_unit.sv =====
// Result words pass the stage 1, 2 and 3 registers into the output register. One pixel
// per clock unless the output stalls; every stage has its own valid bit and loads when
// it is empty or its content moves on, so bubbles are squeezed out and the input keeps
// flowing while a result waits at the output. The line buffers use one read and one
// write port. Reset (rst_ni low, asynchronous) empties the pipeline, clears the counters
// and window and loads the default registers; line buffer contents are left as they are.
module sobel_edge_classifier_unit
  import sobel_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
  input  logic                  s_axis_tuser,   // start_of_frame
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [10:0] grad_x, [21:11] grad_y,
                                                // [42:22] magnitude_sq, [44:43] edge_class,
                                                // [47:45] zero
  output logic                  m_axis_tlast    // end_of_row
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The width is clamped into its legal range when it
  // is written, so the pixel path only ever sees a usable row length.
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0] width_q;
  logic [THR_W-1:0]   strong_thr_q;
  logic [THR_W-1:0]   weak_thr_q;
  logic [WIDTH_W-1:0] width_wr;

  always_comb begin
    width_wr = cfg_data_i[WIDTH_W-1:0];
    if (width_wr < WIDTH_W'(MIN_WIDTH)) begin
      width_wr = WIDTH_W'(MIN_WIDTH);
    end else if (width_wr > WIDTH_W'(MAX_WIDTH)) begin
      width_wr = WIDTH_W'(MAX_WIDTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RESET;
      strong_thr_q <= STRONG_RESET;
      weak_thr_q   <= WEAK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_IMAGE_WIDTH: width_q      <= width_wr;
        REG_STRONG_THR:  strong_thr_q <= cfg_data_i[THR_W-1:0];
        REG_WEAK_THR:    weak_thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain. Each stage loads when it is empty or when the stage after
  // it takes its content in the same cycle.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic in_acc, s1_xfer, s2_xfer, s3_xfer;

  assign s4_ready      = !s4_valid_q || m_axis_tready;
  assign s3_ready      = !s3_valid_q || s4_ready;
  assign s2_ready      = !s2_valid_q || s3_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;

  assign in_acc  = s_axis_tvalid && s1_ready;
  assign s1_xfer = s1_valid_q && s2_ready;
  assign s2_xfer = s2_valid_q && s3_ready;
  assign s3_xfer = s3_valid_q && s4_ready;

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking. A frame start clears the counters before the
  // pixel is placed. The row count only needs to tell rows 0, 1 and "2 or
  // more" apart, so it saturates at two.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [1:0]       row_q, row_d, row_cur;
  logic             last_cur, emit_cur;
  logic [PIX_W-1:0] pix_in;

  assign pix_in = s_axis_tdata[PIX_W-1:0];

  always_comb begin
    col_cur  = s_axis_tuser ? '0 : col_q;
    row_cur  = s_axis_tuser ? '0 : row_q;
    last_cur = ({1'b0, col_cur} + WIDTH_W'(1)) >= width_q;
    emit_cur = (col_cur >= COL_W'(2)) && (row_cur == 2'd2);
    if (last_cur) begin
      col_d = '0;
      row_d = (row_cur == 2'd2) ? 2'd2 : row_cur + 2'd1;
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: both rows share one memory word, {middle, upper}. The read
  // is issued when the pixel is accepted; the write back happens when that
  // pixel leaves stage 1. If the pixel being accepted addresses the column that
  // stage 1 writes in the same cycle (only after a frame start right behind a
  // first-column pixel), the write data is forwarded instead.
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] lbuf_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic             s1_last_q, s1_emit_q, s1_byp_q;
  logic [COL_W-1:0] s1_idx_q;
  logic [PIX_W-1:0] s1_pix_q, s1_byp_up_q, s1_byp_mid_q;
  logic [PIX_W-1:0] top_s1, mid_s1;
  logic             byp_d;

  assign top_s1 = s1_byp_q ? s1_byp_up_q  : rd_q[PIX_W-1:0];
  assign mid_s1 = s1_byp_q ? s1_byp_mid_q : rd_q[2*PIX_W-1:PIX_W];
  assign byp_d  = s1_xfer && (s1_idx_q == col_cur);

  always_ff @(posedge clk_i) begin
    if (s1_xfer) begin
      lbuf_mem[s1_idx_q] <= {s1_pix_q, mid_s1};
    end
    if (in_acc) begin
      rd_q <= lbuf_mem[col_cur];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q     <= col_cur;
      s1_pix_q     <= pix_in;
      s1_last_q    <= last_cur;
      s1_emit_q    <= emit_cur;
      s1_byp_q     <= byp_d;
      s1_byp_up_q  <= mid_s1;
      s1_byp_mid_q <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: the window holds the two previous columns; together with the
  // current column it forms the 3x3 neighborhood. Pixels that produce no result
  // still shift the window but are dropped from the pipeline here.
  // win_q[0..2] is two columns back (top, middle, bottom), win_q[3..5] one back.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]          win_q [6];
  logic signed [GRAD_W-1:0]  gx_d, gy_d;
  logic signed [GRAD_W-1:0]  lt, lm, lb, ct, cb, t, m, b;
  logic signed [GRAD_W-1:0]  s2_gx_q, s2_gy_q;
  logic                      s2_last_q;

  always_comb begin
    lt   = $signed({3'b000, win_q[0]});
    lm   = $signed({3'b000, win_q[1]});
    lb   = $signed({3'b000, win_q[2]});
    ct   = $signed({3'b000, win_q[3]});
    cb   = $signed({3'b000, win_q[5]});
    t    = $signed({3'b000, top_s1});
    m    = $signed({3'b000, mid_s1});
    b    = $signed({3'b000, s1_pix_q});
    gx_d = (t - lt) + ((m - lm) <<< 1) + (b - lb);
    gy_d = (lb + (cb <<< 1) + b) - (lt + (ct <<< 1) + t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_xfer) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_s1;
      win_q[4] <= mid_s1;
      win_q[5] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_xfer) begin
      s2_gx_q   <= gx_d;
      s2_gy_q   <= gy_d;
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> 3: one squarer per gradient, registered before the sum.
  // ---------------------------------------------------------------------------
  logic signed [2*GRAD_W-1:0] gx_sq_full, gy_sq_full;
  logic [SQ_W-1:0]            s3_gx_sq_q, s3_gy_sq_q;
  logic signed [GRAD_W-1:0]   s3_gx_q, s3_gy_q;
  logic                       s3_last_q;

  assign gx_sq_full = s2_gx_q * s2_gx_q;
  assign gy_sq_full = s2_gy_q * s2_gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_xfer) begin
      s3_gx_sq_q <= gx_sq_full[SQ_W-1:0];
      s3_gy_sq_q <= gy_sq_full[SQ_W-1:0];
      s3_gx_q    <= s2_gx_q;
      s3_gy_q    <= s2_gy_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 -> output register: squared magnitude and its class against the
  // squared thresholds. The strong test has priority.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]         mag_d, s4_mag_q;
  edge_class_e              class_d, s4_class_q;
  logic signed [GRAD_W-1:0] s4_gx_q, s4_gy_q;
  logic                     s4_last_q;

  always_comb begin
    mag_d = {1'b0, s3_gx_sq_q} + {1'b0, s3_gy_sq_q};
    priority if (mag_d > strong_thr_q) begin
      class_d = EDGE_STRONG;
    end else if (mag_d > weak_thr_q) begin
      class_d = EDGE_WEAK;
    end else begin
      class_d = EDGE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_xfer) begin
      s4_mag_q   <= mag_d;
      s4_class_q <= class_d;
      s4_gx_q    <= s3_gx_q;
      s4_gy_q    <= s3_gy_q;
      s4_last_q  <= s3_last_q;
    end
  end

  assign m_axis_tvalid = s4_valid_q;
  assign m_axis_tlast  = s4_last_q;
  assign m_axis_tdata  = {3'b000, s4_class_q, s4_mag_q, s4_gy_q, s4_gx_q};

endmodule

// ===== rtl/core/sobel_chk.sv =====
module sobel_chk
  import sobel_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_TDATA_W-1:0]  m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic signed [GRAD_W-1:0]   gx, gy;
  logic signed [2*GRAD_W:0]   mag_ref;

  assign gx      = $signed(m_axis_tdata[10:0]);
  assign gy      = $signed(m_axis_tdata[21:11]);
  assign mag_ref = (2*GRAD_W+1)'(gx * gx) + (2*GRAD_W+1)'(gy * gy);

  // The pipeline is empty straight after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result word valid during reset");

  // With nothing waiting at the output every stage can move, so input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // Magnitude field matches the two gradient fields of the same word, and the top three bits are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[42:22] == mag_ref[MAG_W-1:0])
                      && (m_axis_tdata[47:45] == 3'b000))
    else $error("magnitude does not match gradients");

endmodule

bind sobel_edge_classifier_unit sobel_chk u_sobel_chk (.*);

// ===== bench/tb_sobel_edge_classifier_unit.sv =====
`timescale 1ns / 100ps

module tb_sobel_edge_classifier_unit;
  import sobel_pkg::*;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned LATENCY     = 4;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned ROW_LIMIT   = 65535;
  localparam int unsigned THR_MAX     = (1 << THR_W) - 1;

  // Bit positions of the result fields inside m_axis_tdata, lowest first.
  localparam int unsigned GX_LSB  = 0;
  localparam int unsigned GY_LSB  = GX_LSB + GRAD_W;
  localparam int unsigned MAG_LSB = GY_LSB + GRAD_W;
  localparam int unsigned CLS_LSB = MAG_LSB + MAG_W;
  localparam int unsigned PAD_LSB = CLS_LSB + CLASS_W;
  localparam int unsigned PAD_W   = M_TDATA_W - PAD_LSB;

  typedef enum int unsigned {
    PIX_UNIFORM,
    PIX_SMOOTH,
    PIX_BINARY
  } pixel_mode_e;

  // One expected window result, held at the widths of the output word.
  typedef struct {
    logic [GRAD_W-1:0] grad_x;
    logic [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]  magnitude_sq;
    edge_class_e       edge_class;
    logic              end_of_row;
  } window_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // [7:0] pixel
  logic                  s_axis_tuser;   // start_of_frame
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // [10:0] grad_x, [21:11] grad_y,
                                         // [42:22] magnitude_sq, [44:43] edge_class,
                                         // [47:45] zero
  logic                  m_axis_tlast;   // end_of_row

  sobel_edge_classifier_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Shadow of the block: configuration, line buffers, window and counters.
  // The line buffers start out unknown, just like the hardware; an unknown
  // entry reads as zero in the integer arithmetic below.
  logic [WIDTH_W-1:0] width_reg;
  logic [THR_W-1:0]   strong_thr;
  logic [THR_W-1:0]   weak_thr;
  logic [PIX_W-1:0]   upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0]   middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]   win_cols   [6];
  int unsigned        col_count;
  int unsigned        row_count;

  window_result_t pending_gradients[$];
  int unsigned    error_count = 0;

  // Knobs shared between the test tasks, the pixel sender and the result sink process.
  bit          src_gaps_on  = 1'b1;
  bit          sink_gaps_on = 1'b1;
  int unsigned long_stall_cycles = 0;

  // Takes one accepted pixel through the shadow model. When the window is
  // complete, the gradients, the squared magnitude and the class are queued.
  task automatic advance_sobel_window(logic [PIX_W-1:0] pix, logic sof);
    int unsigned    w, col;
    int             t, m, b, lt, lm, lb, ct, cb, gx, gy, mag;
    logic           last;
    window_result_t res;
    w = int'(width_reg);
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (sof) begin
      col_count = 0;
      row_count = 0;
    end
    col  = col_count;
    last = (col + 1 >= w);
    t = upper_row[col];
    m = middle_row[col];
    b = pix;
    upper_row[col]  = PIX_W'(m);
    middle_row[col] = pix;
    if (col >= 2 && row_count >= 2) begin
      lt = win_cols[0];
      lm = win_cols[1];
      lb = win_cols[2];
      ct = win_cols[3];
      cb = win_cols[5];
      gx = (t - lt) + 2 * (m - lm) + (b - lb);
      gy = (lb + 2 * cb + b) - (lt + 2 * ct + t);
      mag = gx * gx + gy * gy;
      res.grad_x       = GRAD_W'(gx);
      res.grad_y       = GRAD_W'(gy);
      res.magnitude_sq = MAG_W'(mag);
      // The strong test wins even when the thresholds are out of order.
      if (mag > int'(strong_thr)) begin
        res.edge_class = EDGE_STRONG;
      end else if (mag > int'(weak_thr)) begin
        res.edge_class = EDGE_WEAK;
      end else begin
        res.edge_class = EDGE_NONE;
      end
      res.end_of_row = last;
      pending_gradients = {pending_gradients, res};
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = PIX_W'(t);
    win_cols[4] = PIX_W'(m);
    win_cols[5] = pix;
    if (last) begin
      col_count = 0;
      if (row_count < ROW_LIMIT) row_count++;
    end else begin
      col_count = col + 1;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      // Reports are capped so that a badly broken block cannot flood the log.
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  // Every word taken from the result stream is compared with the oldest
  // expected window. Sampling happens at the rising edge, before the block
  // updates its registers for the next cycle.
  always @(posedge clk_i) begin : result_monitor
    window_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_gradients.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result word, expected none, actual %0h", $time,
                   m_axis_tdata);
        end
      end else begin
        want = pending_gradients.pop_front();
        check_field("grad_x", want.grad_x, m_axis_tdata[GX_LSB +: GRAD_W]);
        check_field("grad_y", want.grad_y, m_axis_tdata[GY_LSB +: GRAD_W]);
        check_field("magnitude_sq", want.magnitude_sq, m_axis_tdata[MAG_LSB +: MAG_W]);
        check_field("edge_class", want.edge_class, m_axis_tdata[CLS_LSB +: CLASS_W]);
        check_field("padding", '0, m_axis_tdata[PAD_LSB +: PAD_W]);
        check_field("end_of_row", want.end_of_row, m_axis_tlast);
      end
    end
  end

  // The receiver draws a hold-off before each result word. A long hold-off
  // requested by a test is taken once, after the next word, and lets the
  // pipeline fill up until the block stops taking pixels.
  always begin : result_sink
    int unsigned hold;
    @(negedge clk_i);
    if (long_stall_cycles != 0) begin
      hold = long_stall_cycles;
      long_stall_cycles = 0;
    end else begin
      hold = sink_gaps_on ? $urandom_range(0, 5) : 0;
    end
    if (hold != 0) begin
      m_axis_tready <= 1'b0;
      repeat (hold) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
    do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
  end

  // Sends one pixel word. The valid stays high from one word to the next when
  // no gap is drawn, so back-to-back words are really back to back.
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic sof);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_sobel_window(pix, sof);
  endtask

  task automatic send_row3(logic [PIX_W-1:0] p0, logic [PIX_W-1:0] p1,
                           logic [PIX_W-1:0] p2, logic sof);
    send_pixel(p0, sof);
    send_pixel(p1, 1'b0);
    send_pixel(p2, 1'b0);
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel(pixel_mode_e mode);
    case (mode)
      PIX_SMOOTH: return PIX_W'(96 + $urandom_range(0, 31));
      PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:    return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned draw_threshold();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, THR_MAX);
      1:       return $urandom_range(0, 20000);
      2:       return $urandom_range(40000, 120000);
      default: return $urandom_range(0, 1) ? THR_MAX : 0;
    endcase
  endfunction

  // Sends a whole frame of the given row length, start of frame on the first word.
  task automatic send_frame(int unsigned w, int unsigned rows, pixel_mode_e mode);
    for (int unsigned i = 0; i < w * rows; i++) begin
      send_pixel(draw_pixel(mode), i == 0);
    end
  endtask

  // Lets the block run dry: every expected word has arrived, and pixels that
  // cause no result have had time to leave the pipeline as well.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: width_reg  = value[WIDTH_W-1:0];
      REG_STRONG_THR:  strong_thr = value[THR_W-1:0];
      REG_WEAK_THR:    weak_thr   = value[THR_W-1:0];
      default: ;
    endcase
  endtask

  // The first frame runs on the reset settings: 640 pixels per row and the
  // default thresholds. After the first row and a few pixels of the second,
  // the width drops to three, so the rows that follow soon give results and
  // their position shows where the first row ended.
  task automatic test_reset_defaults();
    send_frame(640, 1, PIX_UNIFORM);
    for (int i = 0; i < 3; i++) send_pixel(draw_pixel(PIX_UNIFORM), 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 3);
    for (int i = 0; i < 7; i++) send_pixel(draw_pixel(PIX_UNIFORM), 1'b0);
  endtask

  // Pure horizontal and vertical steps between 0 and 255 drive both gradients
  // to their full positive and negative swing.
  task automatic test_gradient_extremes();
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 3);
    send_row3(8'h00, 8'h00, 8'h00, 1'b1);
    send_row3(8'h00, 8'h00, 8'h00, 1'b0);
    send_row3(8'h00, 8'h00, 8'h00, 1'b0);
    send_row3(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_row3(8'h00, 8'h00, 8'h00, 1'b0);
    send_row3(8'h00, 8'h00, 8'h00, 1'b0);
    repeat (3) send_row3(8'h00, 8'h80, 8'hFF, 1'b0);
    repeat (3) send_row3(8'hFF, 8'h80, 8'h00, 1'b0);
  endtask

  // Rows of 0,0,1 give a magnitude of exactly 16. The thresholds are moved
  // around that value: equal means no edge, out of order still tests strong
  // first, and the extremes of the register range are used.
  task automatic test_threshold_order();
    int unsigned strong_set[6] = '{15, 16, 0, THR_MAX, THR_MAX, 16};
    int unsigned weak_set[6]   = '{16, 16, 0, THR_MAX, 0, 0};
    wait_idle();
    write_reg(REG_STRONG_THR, 16);
    write_reg(REG_WEAK_THR, 15);
    send_row3(8'h00, 8'h00, 8'h01, 1'b1);
    send_row3(8'h00, 8'h00, 8'h01, 1'b0);
    send_row3(8'h00, 8'h00, 8'h01, 1'b0);
    for (int i = 0; i < 6; i++) begin
      wait_idle();
      write_reg(REG_STRONG_THR, strong_set[i]);
      write_reg(REG_WEAK_THR, weak_set[i]);
      send_row3(8'h00, 8'h00, 8'h01, 1'b0);
    end
  endtask

  // Widths below the minimum act as three. A width above the line buffer
  // depth acts as the full depth: the first row has to end after that many
  // pixels, which shows once the width drops to three as in the reset test.
  task automatic test_width_limits();
    int unsigned written[4] = '{0, 1, 2, 3};
    for (int i = 0; i < 4; i++) begin
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, written[i]);
      write_reg(REG_STRONG_THR, draw_threshold());
      write_reg(REG_WEAK_THR, draw_threshold());
      send_frame(3, 3, pixel_mode_e'(i % 3));
    end
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_STRONG_THR, draw_threshold());
    write_reg(REG_WEAK_THR, draw_threshold());
    send_frame(MAX_WIDTH, 1, PIX_SMOOTH);
    for (int i = 0; i < 3; i++) send_pixel(draw_pixel(PIX_SMOOTH), 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 3);
    for (int i = 0; i < 7; i++) send_pixel(draw_pixel(PIX_BINARY), 1'b0);
  endtask

  // The frame stops in the middle of a row at column 5, and the width drops
  // to three. The next pixel lies past the new last column and has to end
  // the row; the following rows run at the new width.
  task automatic test_width_shrink_mid_row();
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 8);
    write_reg(REG_STRONG_THR, 90000);
    write_reg(REG_WEAK_THR, 62500);
    send_frame(8, 3, PIX_UNIFORM);
    for (int i = 0; i < 5; i++) send_pixel(draw_pixel(PIX_UNIFORM), 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 3);
    for (int i = 0; i < 7; i++) send_pixel(draw_pixel(PIX_UNIFORM), 1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering pixels without a gap, so the block fills and stalls its input.
  task automatic test_output_backpressure();
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 16);
    src_gaps_on = 1'b0;
    long_stall_cycles = 300;
    send_frame(16, 4, PIX_UNIFORM);
    src_gaps_on = 1'b1;
  endtask

  // Random frames, mostly small and well formed. Some are cut short or get
  // a stray start of frame in the middle; configuration changes only while
  // the block is idle and always before a new frame.
  task automatic test_random_frames(int unsigned item_goal);
    int unsigned sent, w, rows, n;
    pixel_mode_e mode;
    sent = 0;
    w    = 3;
    while (sent < item_goal) begin
      if (sent == 0 || $urandom_range(0, 1) == 0) begin
        wait_idle();
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_STRONG_THR, draw_threshold());
        write_reg(REG_WEAK_THR, draw_threshold());
      end
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      mode = pixel_mode_e'($urandom_range(0, 2));
      rows = $urandom_range(3, 8);
      n    = w * rows;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      if (n > item_goal - sent) n = item_goal - sent;
      for (int unsigned i = 0; i < n; i++) begin
        send_pixel(draw_pixel(mode), (i == 0) || ($urandom_range(0, 199) == 0));
      end
      sent += n;
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_IMAGE_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    width_reg     = WIDTH_RESET;
    strong_thr    = STRONG_RESET;
    weak_thr      = WEAK_RESET;
    foreach (win_cols[i]) win_cols[i] = '0;
    col_count     = 0;
    row_count     = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_gradient_extremes();
    test_threshold_order();
    test_width_limits();
    test_width_shrink_mid_row();
    test_output_backpressure();
    test_random_frames(100);

    wait_idle();
    if (error_count == 0 && pending_gradients.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sobel_pkg.sv
rtl/core/sobel_edge_classifier_unit.sv
rtl/core/sobel_chk.sv
bench/tb_sobel_edge_classifier_unit.sv
